// ===== sv/lst_pkg.sv =====
// Shared types, codes and character-class helpers for the Lisp source tokenizer.
// No dependencies.
package lst_pkg;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_HALT      = 4'd1,
    M_NUM       = 4'd2,
    M_DASH      = 4'd3,
    M_IDENT     = 4'd4,
    M_STR       = 4'd5,
    M_COMMENT   = 4'd6,
    M_HASH      = 4'd7,
    M_CHAR_BS   = 4'd8,
    M_CHAR_VAL  = 4'd9,
    M_LANG      = 4'd10,
    M_LANG_TAIL = 4'd11
  } mode_t;

  localparam logic [2:0] K_LANG    = 3'd0;
  localparam logic [2:0] K_COMMENT = 3'd1;
  localparam logic [2:0] K_PUNCT   = 3'd2;
  localparam logic [2:0] K_NUMBER  = 3'd3;
  localparam logic [2:0] K_STRING  = 3'd4;
  localparam logic [2:0] K_CHAR    = 3'd5;
  localparam logic [2:0] K_BOOL    = 3'd6;
  localparam logic [2:0] K_IDENT   = 3'd7;

  localparam logic [2:0] F_NONE     = 3'd0;
  localparam logic [2:0] F_BAD_CHAR = 3'd1;
  localparam logic [2:0] F_BAD_HASH = 3'd2;
  localparam logic [2:0] F_TWO_DOTS = 3'd3;
  localparam logic [2:0] F_OPEN_STR = 3'd4;

  localparam logic [3:0] LANG_LAST = 4'd10;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_char;
    logic       held_valid;
    logic       held_is_first;
    logic       dot_seen;
    logic [3:0] match_pos;
  } tok_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value_char;
    logic       first;
    logic       last;
    logic       empty_res;
    logic [2:0] fault;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] v,
                                  input logic f, input logic l, input logic e,
                                  input logic [2:0] flt);
    res_t r;
    r.kind       = kind;
    r.value_char = v;
    r.first      = f;
    r.last       = l;
    r.empty_res  = e;
    r.fault      = flt;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "!");
  endfunction

  // "lang racket", indexed by match position
  function automatic logic [7:0] lang_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "l";
      4'd1:    r = "a";
      4'd2:    r = "n";
      4'd3:    r = "g";
      4'd4:    r = " ";
      4'd5:    r = "r";
      4'd6:    r = "a";
      4'd7:    r = "c";
      4'd8:    r = "k";
      4'd9:    r = "e";
      4'd10:   r = "t";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/lisp_source_tokenizer.sv =====
// Lisp source tokenizer top level: scanner state, step logic and result queue.
// Depends on lst_pkg.
// Results of an accepted character are registered into the result queue.
// Throughput: one character per cycle while in_stall is low; a character can give two
// results, absorbed by a four-entry result queue (in_stall while it holds > 2).
// Reset (synchronous): scanner returns to idle, held state cleared, queue emptied.
module lisp_source_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          ch,
  input  logic                line_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          kind,
  output logic [7:0]          value_char,
  output logic                first,
  output logic                last,
  output logic                empty_res,
  output logic [2:0]          fault
);
  import lst_pkg::*;

  tok_state_t st, st_next;
  res_t       res [2];
  logic [1:0] n_res;
  logic       do_idle, do_ident, acc, pop;

  res_t       fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign in_stall  = (count > 3'd2);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    st_next  = st;
    res[0]   = '0;
    res[1]   = '0;
    n_res    = 2'd0;
    do_idle  = 1'b0;
    do_ident = 1'b0;
    if (acc) begin
      unique case (st.mode)
        M_HALT: ;
        M_IDLE: do_idle = 1'b1;
        M_NUM: begin
          if (is_digit(ch) || ch == ".") begin
            if (ch == "." && st.dot_seen) begin
              st_next.mode = M_HALT;
              res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_TWO_DOTS);
              n_res = n_res + 2'd1;
            end else begin
              if (ch == ".") st_next.dot_seen = 1'b1;
              res[n_res[0]] = mk_res(K_NUMBER, st.held_char, st.held_is_first, 1'b0,
                                     1'b0, F_NONE);
              n_res = n_res + 2'd1;
              st_next.held_is_first = 1'b0;
              if (line_end) begin
                res[n_res[0]] = mk_res(K_NUMBER, ch, 1'b0, 1'b1, 1'b0, F_NONE);
                n_res = n_res + 2'd1;
                st_next.mode = M_IDLE;
              end else begin
                st_next.held_char = ch;
              end
            end
          end else begin
            res[n_res[0]] = mk_res(K_NUMBER, st.held_char, st.held_is_first, 1'b1,
                                   1'b0, F_NONE);
            n_res = n_res + 2'd1;
            st_next.mode = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_DASH: begin
          if (is_digit(ch)) begin
            res[n_res[0]] = mk_res(K_NUMBER, "-", 1'b1, 1'b0, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
            if (line_end) begin
              res[n_res[0]] = mk_res(K_NUMBER, ch, 1'b0, 1'b1, 1'b0, F_NONE);
              n_res = n_res + 2'd1;
              st_next.mode = M_IDLE;
            end else begin
              st_next.mode          = M_NUM;
              st_next.held_char     = ch;
              st_next.held_valid    = 1'b1;
              st_next.held_is_first = 1'b0;
              st_next.dot_seen      = 1'b0;
            end
          end else begin
            st_next.mode          = M_IDENT;
            st_next.held_char     = "-";
            st_next.held_valid    = 1'b1;
            st_next.held_is_first = 1'b1;
            do_ident = 1'b1;
          end
        end
        M_IDENT: do_ident = 1'b1;
        M_STR: begin
          if (ch == "\"") begin
            if (st.held_valid)
              res[n_res[0]] = mk_res(K_STRING, st.held_char, st.held_is_first, 1'b1,
                                     1'b0, F_NONE);
            else
              res[n_res[0]] = mk_res(K_STRING, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
            n_res = n_res + 2'd1;
            st_next.held_valid = 1'b0;
            st_next.mode       = M_IDLE;
          end else if (line_end) begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_OPEN_STR);
            n_res = n_res + 2'd1;
          end else begin
            if (st.held_valid) begin
              res[n_res[0]] = mk_res(K_STRING, st.held_char, st.held_is_first, 1'b0,
                                     1'b0, F_NONE);
              n_res = n_res + 2'd1;
              st_next.held_is_first = 1'b0;
            end
            st_next.held_char  = ch;
            st_next.held_valid = 1'b1;
          end
        end
        M_COMMENT: begin
          res[n_res[0]] = mk_res(K_COMMENT, ch, st.held_is_first, line_end, 1'b0, F_NONE);
          n_res = n_res + 2'd1;
          st_next.held_is_first = 1'b0;
          if (line_end) st_next.mode = M_IDLE;
        end
        M_HASH: begin
          if (ch == "\\") begin
            if (line_end) begin
              st_next.mode = M_IDLE;
              res[n_res[0]] = mk_res(K_CHAR, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
              n_res = n_res + 2'd1;
            end else begin
              st_next.mode = M_CHAR_BS;
            end
          end else if (ch == "t" || ch == "f") begin
            st_next.mode = M_IDLE;
            res[n_res[0]] = mk_res(K_BOOL, ch, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
          end else if (ch == "l" && !line_end) begin
            st_next.mode      = M_LANG;
            st_next.match_pos = 4'd1;
          end else begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_BAD_HASH);
            n_res = n_res + 2'd1;
          end
        end
        M_CHAR_BS: begin
          if (line_end) begin
            st_next.mode = M_IDLE;
            res[n_res[0]] = mk_res(K_CHAR, ch, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
          end else begin
            st_next.held_char  = ch;
            st_next.held_valid = 1'b1;
            st_next.mode       = M_CHAR_VAL;
          end
        end
        M_CHAR_VAL: begin
          if (is_alpha(ch)) begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_BAD_CHAR);
            n_res = n_res + 2'd1;
          end else begin
            res[n_res[0]] = mk_res(K_CHAR, st.held_char, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
            st_next.mode = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_LANG: begin
          if (st.match_pos > LANG_LAST || ch != lang_char(st.match_pos) ||
              (st.match_pos != LANG_LAST && line_end)) begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_BAD_HASH);
            n_res = n_res + 2'd1;
          end else if (st.match_pos == LANG_LAST) begin
            if (line_end) begin
              st_next.mode = M_IDLE;
              res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
              n_res = n_res + 2'd1;
            end else begin
              st_next.mode = M_LANG_TAIL;
            end
          end else begin
            st_next.match_pos = st.match_pos + 4'd1;
          end
        end
        M_LANG_TAIL: begin
          st_next.mode = M_HALT;
          res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_BAD_HASH);
          n_res = n_res + 2'd1;
        end
        default: st_next.mode = M_IDLE;
      endcase

      if (do_ident) begin
        if (is_ident(ch)) begin
          res[n_res[0]] = mk_res(K_IDENT, st_next.held_char, st_next.held_is_first,
                                 1'b0, 1'b0, F_NONE);
          n_res = n_res + 2'd1;
          st_next.held_is_first = 1'b0;
          if (line_end) begin
            res[n_res[0]] = mk_res(K_IDENT, ch, 1'b0, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
            st_next.mode = M_IDLE;
          end else begin
            st_next.held_char = ch;
          end
        end else begin
          res[n_res[0]] = mk_res(K_IDENT, st_next.held_char, st_next.held_is_first,
                                 1'b1, 1'b0, F_NONE);
          n_res = n_res + 2'd1;
          st_next.mode = M_IDLE;
          do_idle = 1'b1;
        end
      end

      if (do_idle) begin
        if (ch == " ") begin
        end else if (ch == "#") begin
          if (line_end) begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_BAD_HASH);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode = M_HASH;
          end
        end else if (ch == ";") begin
          if (line_end) begin
            res[n_res[0]] = mk_res(K_COMMENT, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode          = M_COMMENT;
            st_next.held_is_first = 1'b1;
          end
        end else if (ch == "(" || ch == ")" || ch == "[" || ch == "]" || ch == "'" ||
                     ch == ".") begin
          res[n_res[0]] = mk_res(K_PUNCT, ch, 1'b1, 1'b1, 1'b0, F_NONE);
          n_res = n_res + 2'd1;
        end else if (is_digit(ch)) begin
          if (line_end) begin
            res[n_res[0]] = mk_res(K_NUMBER, ch, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode          = M_NUM;
            st_next.held_char     = ch;
            st_next.held_valid    = 1'b1;
            st_next.held_is_first = 1'b1;
            st_next.dot_seen      = 1'b0;
          end
        end else if (ch == "-") begin
          if (line_end) begin
            res[n_res[0]] = mk_res(K_IDENT, ch, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode = M_DASH;
          end
        end else if (ch == "\"") begin
          if (line_end) begin
            st_next.mode = M_HALT;
            res[n_res[0]] = mk_res(K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, F_OPEN_STR);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode          = M_STR;
            st_next.held_valid    = 1'b0;
            st_next.held_is_first = 1'b1;
          end
        end else if (is_ident(ch)) begin
          if (line_end) begin
            res[n_res[0]] = mk_res(K_IDENT, ch, 1'b1, 1'b1, 1'b0, F_NONE);
            n_res = n_res + 2'd1;
          end else begin
            st_next.mode          = M_IDENT;
            st_next.held_char     = ch;
            st_next.held_valid    = 1'b1;
            st_next.held_is_first = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '{mode: M_IDLE, default: '0};
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      st     <= st_next;
      wr_ptr <= wr_ptr + n_res;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, n_res} - {2'b00, pop};
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) fifo[wr_ptr] <= res[0];
    if (n_res == 2'd2) fifo[wr_ptr + 2'd1] <= res[1];
  end

  assign kind       = fifo[rd_ptr].kind;
  assign value_char = fifo[rd_ptr].value_char;
  assign first      = fifo[rd_ptr].first;
  assign last       = fifo[rd_ptr].last;
  assign empty_res  = fifo[rd_ptr].empty_res;
  assign fault      = fifo[rd_ptr].fault;

endmodule

// ===== sv/lst_checker.sv =====
// Port-level checks for lisp_source_tokenizer, bound to the top level.
// Depends on lst_pkg.
module lst_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] value_char,
  input logic       first,
  input logic       last,
  input logic       empty_res,
  input logic [2:0] fault
);
  import lst_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value_char) &&
    $stable(first) && $stable(last) && $stable(empty_res) && $stable(fault))
    else $error("stalled result changed");

  a_fault_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault != F_NONE |-> kind == K_LANG && !first && !last && !empty_res)
    else $error("malformed fault result");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> first && last && value_char == 8'd0)
    else $error("malformed empty token");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && fault != F_NONE |=> !out_valid)
    else $error("result after fault transfer");

endmodule

bind lisp_source_tokenizer lst_checker u_lst_checker (.*);

// ===== bench/lisp_source_tokenizer_tb.sv =====
// Testbench for lisp_source_tokenizer: streams directed and random source lines,
// predicts every token character and checks each result transfer in order.
// Depends on lst_pkg and lisp_source_tokenizer.
module lisp_source_tokenizer_tb;
  import lst_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 80;
  localparam logic [87:0] LANG_TEXT   = "lang racket";
  localparam logic [47:0] PUNCT_SET   = "()[]'.";
  localparam logic [39:0] SYMBOL_SET  = "+-*/!";

  typedef struct packed {
    logic [1:0]  n;
    res_t [2:0]  r;
  } scan_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] ch = 8'd0;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] value_char;
  logic       first;
  logic       last;
  logic       empty_res;
  logic [2:0] fault;

  tok_state_t scan_state = '0;
  res_t       token_chars_due[$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         gaps_on = 1'b1;
  int         hold_asks = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  lisp_source_tokenizer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .line_end   (line_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value_char (value_char),
    .first      (first),
    .last       (last),
    .empty_res  (empty_res),
    .fault      (fault)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lisp_source_tokenizer_tb NOT OK");
      $finish;
    end
  end

  function automatic logic numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return letter(c) || (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "!");
  endfunction

  function automatic void emit(inout scan_out_t o, input logic [2:0] k, input logic [7:0] v,
                               input logic f, input logic l, input logic e,
                               input logic [2:0] code);
    res_t tmp;
    tmp.kind       = k;
    tmp.value_char = v;
    tmp.first      = f;
    tmp.last       = l;
    tmp.empty_res  = e;
    tmp.fault      = code;
    o.r[o.n] = tmp;
    o.n = o.n + 2'd1;
  endfunction

  function automatic void stop_scan(inout tok_state_t s, inout scan_out_t o,
                                    input logic [2:0] code);
    s.mode = M_HALT;
    emit(o, K_LANG, 8'd0, 1'b0, 1'b0, 1'b0, code);
  endfunction

  function automatic void idle_scan(inout tok_state_t s, inout scan_out_t o,
                                    input logic [7:0] c, input logic le);
    if (c == " ") begin
    end else if (c == "#") begin
      if (le) stop_scan(s, o, F_BAD_HASH);
      else s.mode = M_HASH;
    end else if (c == ";") begin
      if (le) emit(o, K_COMMENT, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
      else begin
        s.mode = M_COMMENT;
        s.held_is_first = 1'b1;
      end
    end else if ((c == "(") || (c == ")") || (c == "[") || (c == "]") || (c == "'") ||
                 (c == ".")) begin
      emit(o, K_PUNCT, c, 1'b1, 1'b1, 1'b0, F_NONE);
    end else if (numeral(c)) begin
      if (le) emit(o, K_NUMBER, c, 1'b1, 1'b1, 1'b0, F_NONE);
      else begin
        s.mode = M_NUM;
        s.held_char = c;
        s.held_valid = 1'b1;
        s.held_is_first = 1'b1;
        s.dot_seen = 1'b0;
      end
    end else if (c == "-") begin
      if (le) emit(o, K_IDENT, c, 1'b1, 1'b1, 1'b0, F_NONE);
      else s.mode = M_DASH;
    end else if (c == "\"") begin
      if (le) stop_scan(s, o, F_OPEN_STR);
      else begin
        s.mode = M_STR;
        s.held_valid = 1'b0;
        s.held_is_first = 1'b1;
      end
    end else if (word_char(c)) begin
      if (le) emit(o, K_IDENT, c, 1'b1, 1'b1, 1'b0, F_NONE);
      else begin
        s.mode = M_IDENT;
        s.held_char = c;
        s.held_valid = 1'b1;
        s.held_is_first = 1'b1;
      end
    end
  endfunction

  function automatic void ident_scan(inout tok_state_t s, inout scan_out_t o,
                                     input logic [7:0] c, input logic le);
    if (word_char(c)) begin
      emit(o, K_IDENT, s.held_char, s.held_is_first, 1'b0, 1'b0, F_NONE);
      s.held_is_first = 1'b0;
      if (le) begin
        emit(o, K_IDENT, c, 1'b0, 1'b1, 1'b0, F_NONE);
        s.mode = M_IDLE;
      end else begin
        s.held_char = c;
      end
    end else begin
      emit(o, K_IDENT, s.held_char, s.held_is_first, 1'b1, 1'b0, F_NONE);
      s.mode = M_IDLE;
      idle_scan(s, o, c, le);
    end
  endfunction

  function automatic void scan_step(inout tok_state_t s, output scan_out_t o,
                                    input logic [7:0] c, input logic le);
    o = '0;
    case (s.mode)
      M_HALT: begin
      end
      M_IDLE: idle_scan(s, o, c, le);
      M_NUM: begin
        if (numeral(c) || (c == ".")) begin
          if ((c == ".") && s.dot_seen) stop_scan(s, o, F_TWO_DOTS);
          else begin
            if (c == ".") s.dot_seen = 1'b1;
            emit(o, K_NUMBER, s.held_char, s.held_is_first, 1'b0, 1'b0, F_NONE);
            s.held_is_first = 1'b0;
            if (le) begin
              emit(o, K_NUMBER, c, 1'b0, 1'b1, 1'b0, F_NONE);
              s.mode = M_IDLE;
            end else begin
              s.held_char = c;
            end
          end
        end else begin
          emit(o, K_NUMBER, s.held_char, s.held_is_first, 1'b1, 1'b0, F_NONE);
          s.mode = M_IDLE;
          idle_scan(s, o, c, le);
        end
      end
      M_DASH: begin
        if (numeral(c)) begin
          emit(o, K_NUMBER, "-", 1'b1, 1'b0, 1'b0, F_NONE);
          if (le) begin
            emit(o, K_NUMBER, c, 1'b0, 1'b1, 1'b0, F_NONE);
            s.mode = M_IDLE;
          end else begin
            s.mode = M_NUM;
            s.held_char = c;
            s.held_valid = 1'b1;
            s.held_is_first = 1'b0;
            s.dot_seen = 1'b0;
          end
        end else begin
          s.mode = M_IDENT;
          s.held_char = "-";
          s.held_valid = 1'b1;
          s.held_is_first = 1'b1;
          ident_scan(s, o, c, le);
        end
      end
      M_IDENT: ident_scan(s, o, c, le);
      M_STR: begin
        if (c == "\"") begin
          if (s.held_valid) emit(o, K_STRING, s.held_char, s.held_is_first, 1'b1, 1'b0, F_NONE);
          else emit(o, K_STRING, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
          s.held_valid = 1'b0;
          s.mode = M_IDLE;
        end else if (le) begin
          stop_scan(s, o, F_OPEN_STR);
        end else begin
          if (s.held_valid) begin
            emit(o, K_STRING, s.held_char, s.held_is_first, 1'b0, 1'b0, F_NONE);
            s.held_is_first = 1'b0;
          end
          s.held_char = c;
          s.held_valid = 1'b1;
        end
      end
      M_COMMENT: begin
        emit(o, K_COMMENT, c, s.held_is_first, le, 1'b0, F_NONE);
        s.held_is_first = 1'b0;
        if (le) s.mode = M_IDLE;
      end
      M_HASH: begin
        if (c == "\\") begin
          if (le) begin
            s.mode = M_IDLE;
            emit(o, K_CHAR, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
          end else begin
            s.mode = M_CHAR_BS;
          end
        end else if ((c == "t") || (c == "f")) begin
          s.mode = M_IDLE;
          emit(o, K_BOOL, c, 1'b1, 1'b1, 1'b0, F_NONE);
        end else if ((c == "l") && !le) begin
          s.mode = M_LANG;
          s.match_pos = 4'd1;
        end else begin
          stop_scan(s, o, F_BAD_HASH);
        end
      end
      M_CHAR_BS: begin
        if (le) begin
          s.mode = M_IDLE;
          emit(o, K_CHAR, c, 1'b1, 1'b1, 1'b0, F_NONE);
        end else begin
          s.held_char = c;
          s.held_valid = 1'b1;
          s.mode = M_CHAR_VAL;
        end
      end
      M_CHAR_VAL: begin
        if (letter(c)) stop_scan(s, o, F_BAD_CHAR);
        else begin
          emit(o, K_CHAR, s.held_char, 1'b1, 1'b1, 1'b0, F_NONE);
          s.mode = M_IDLE;
          idle_scan(s, o, c, le);
        end
      end
      M_LANG: begin
        if (s.match_pos > LANG_LAST) stop_scan(s, o, F_BAD_HASH);
        else if (c != LANG_TEXT[8 * (LANG_LAST - s.match_pos) +: 8]) stop_scan(s, o, F_BAD_HASH);
        else if (s.match_pos == LANG_LAST) begin
          if (le) begin
            s.mode = M_IDLE;
            emit(o, K_LANG, 8'd0, 1'b1, 1'b1, 1'b1, F_NONE);
          end else begin
            s.mode = M_LANG_TAIL;
          end
        end else if (le) begin
          stop_scan(s, o, F_BAD_HASH);
        end else begin
          s.match_pos = s.match_pos + 4'd1;
        end
      end
      M_LANG_TAIL: stop_scan(s, o, F_BAD_HASH);
      default: s.mode = M_IDLE;
    endcase
  endfunction

  // result side: checks each transfer, random stalls and the long hold-off
  always @(posedge clk) begin : take_result
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_chars_due.size() == 0) begin
          $error("unexpected result: kind %0d value_char %02h fault %0d", kind, value_char,
                 fault);
          mismatches++;
        end else begin
          want = token_chars_due.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
          end
          if (value_char !== want.value_char) begin
            $error("value_char: expected %02h, got %02h", want.value_char, value_char);
            mismatches++;
          end
          if (first !== want.first) begin
            $error("first: expected %0d, got %0d", want.first, first);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
          end
          if (empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, empty_res);
            mismatches++;
          end
          if (fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, fault);
            mismatches++;
          end
        end
      end
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 14);
      end
    end
  end

  task automatic feed_char(input logic [7:0] c, input logic le);
    scan_out_t o;
    if (gaps_on) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    ch <= c;
    line_end <= le;
    do @(posedge clk); while (in_stall);
    scan_step(scan_state, o, c, le);
    for (int i = 0; i < o.n; i++) token_chars_due.push_back(o.r[i]);
  endtask

  task automatic feed_text(input string s, input logic le_last);
    for (int i = 0; i < s.len(); i++) feed_char(s[i], le_last && (i == s.len() - 1));
  endtask

  // sends the character, or the first substitute that keeps the scanner out of a fault
  task automatic feed_safe(input logic [7:0] c, input logic le);
    tok_state_t trial;
    scan_out_t  o;
    logic [8:0] options [0:4];
    bit         done;
    options[0] = {le, c};
    options[1] = {1'b0, " "};
    options[2] = {1'b0, "t"};
    options[3] = {scan_state.match_pos == LANG_LAST,
                  LANG_TEXT[8 * (LANG_LAST - scan_state.match_pos) +: 8]};
    options[4] = {le, "\""};
    done = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (!done) begin
        trial = scan_state;
        scan_step(trial, o, options[i][7:0], options[i][8]);
        if ((trial.mode != M_HALT) && (trial.mode != M_LANG_TAIL)) begin
          feed_char(options[i][7:0], options[i][8]);
          done = 1'b1;
        end
      end
    end
  endtask

  task automatic wait_all_tokens;
    in_valid <= 1'b0;
    while (token_chars_due.size() != 0) @(posedge clk);
  endtask

  task automatic close_line;
    while (scan_state.mode != M_IDLE) begin
      if (scan_state.mode == M_STR) feed_char("\"", 1'b0);
      else feed_safe(" ", 1'b1);
    end
  endtask

  function automatic logic [7:0] word_glyph;
    if ($urandom_range(3) == 0) return SYMBOL_SET[8 * $urandom_range(4) +: 8];
    if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  task automatic test_directed_tokens;
    feed_text("(.", 1'b0);
    feed_text("-5", 1'b1);
    feed_text("-a", 1'b1);
    feed_text("-", 1'b1);
    feed_text("\"\"", 1'b0);
    feed_text(";", 1'b1);
    feed_text("#\\", 1'b1);
    feed_text("#t", 1'b0);
    feed_char(8'h00, 1'b0);
    feed_char(8'hFF, 1'b1);
    feed_text("7.5 ", 1'b1);
    wait_all_tokens();
  endtask

  task automatic test_random_tokens(input int count, input bit with_gaps);
    logic [8:0] seq[$];
    logic [7:0] b;
    int         sent;
    int         pick;
    bit         ends_line;
    gaps_on = with_gaps;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      ends_line = 1'b0;
      pick = (sent == 0) ? 79 : $urandom_range(99);
      if (pick < 12) begin
        seq.push_back({1'b0, PUNCT_SET[8 * $urandom_range(5) +: 8]});
      end else if (pick < 30) begin
        if ($urandom_range(3) == 0) seq.push_back({1'b0, "-"});
        repeat ($urandom_range(1, 4)) seq.push_back({1'b0, 8'("0" + $urandom_range(9))});
        if ($urandom_range(2) == 0) begin
          seq.push_back({1'b0, "."});
          repeat ($urandom_range(3)) seq.push_back({1'b0, 8'("0" + $urandom_range(9))});
        end
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 5)) seq.push_back({1'b0, word_glyph()});
      end else if (pick < 58) begin
        seq.push_back({1'b0, "\""});
        repeat ($urandom_range(4)) begin
          b = 8'($urandom_range(255));
          if (b == "\"") b = "x";
          seq.push_back({1'b0, b});
        end
        seq.push_back({1'b0, "\""});
      end else if (pick < 66) begin
        seq.push_back({1'b0, ";"});
        repeat ($urandom_range(5)) seq.push_back({1'b0, 8'($urandom_range(255))});
        ends_line = 1'b1;
      end else if (pick < 72) begin
        seq.push_back({1'b0, "#"});
        seq.push_back({1'b0, ($urandom_range(1) == 0) ? "t" : "f"});
      end else if (pick < 78) begin
        seq.push_back({1'b0, "#"});
        seq.push_back({1'b0, "\\"});
        seq.push_back({1'b0, 8'($urandom_range(255))});
      end else if (pick < 81) begin
        seq.push_back({1'b0, "#"});
        for (int i = 0; i <= LANG_LAST; i++)
          seq.push_back({1'b0, LANG_TEXT[8 * (LANG_LAST - i) +: 8]});
        ends_line = 1'b1;
      end else if (pick < 93) begin
        seq.push_back({1'b0, 8'($urandom_range(255))});
      end else begin
        seq.push_back({1'b0, " "});
      end
      if (!ends_line) begin
        pick = $urandom_range(9);
        if (pick < 3) ends_line = 1'b1;
        else if (pick < 7) seq.push_back({1'b0, " "});
      end
      if (ends_line) seq[seq.size() - 1][8] = 1'b1;
      foreach (seq[i]) begin
        feed_safe(seq[i][7:0], seq[i][8]);
        sent++;
      end
    end
    wait_all_tokens();
    gaps_on = 1'b1;
  endtask

  // receiver held off while a long comment streams in, so the result queue backs up
  task automatic test_result_backlog;
    close_line();
    gaps_on = 1'b0;
    hold_asks++;
    feed_char(";", 1'b0);
    repeat (30) feed_char(8'($urandom_range(255)), 1'b0);
    feed_char("z", 1'b1);
    wait_all_tokens();
    gaps_on = 1'b1;
  endtask

  // one fault per run, since reset is not repeated; the block must stay silent after it
  task automatic test_fault_halt;
    close_line();
    case ($urandom_range(3))
      0: feed_text("#\\ab", 1'b0);
      1: feed_text("1.2.", 1'b0);
      2: feed_text("\"ab", 1'b1);
      default: begin
        case ($urandom_range(3))
          0: feed_text("#", 1'b1);
          1: feed_text("#x", 1'b0);
          2: feed_text("#lang rocket", 1'b1);
          default: feed_text("#lang racket!", 1'b0);
        endcase
      end
    endcase
    repeat (10) feed_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_all_tokens();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_tokens();
    test_random_tokens(100, 1'b1);
    test_random_tokens(40, 1'b0);
    test_result_backlog();
    test_fault_halt();
    wait_all_tokens();
    repeat (8) @(posedge clk);
    if ((mismatches == 0) && (token_chars_due.size() == 0)) begin
      $display("lisp_source_tokenizer_tb OK");
    end else begin
      $display("lisp_source_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
